// ----- hdl/hesrch_pkg.sv -----
// Package with shared constants, types and states of the horizon edge point search.
`default_nettype none
package hesrch_pkg;
    localparam int MaxWidth = 512;
    localparam int MaxHeight = 512;
    localparam int ZoneSize = 10;
    localparam int PointCount = 3;
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int AW = XW + YW;
    localparam int SumW = $clog2(ZoneSize * ZoneSize * 256);
    localparam int QDepth = 4;

    localparam logic [1:0] RegWidth = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegThresh = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic [XW-1:0] col;
        logic [YW-1:0] row;
        logic wr;
        logic eof;
    } load_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE, S_COL, S_SUM, S_WAIT, S_EVAL, S_NEXT, S_EMIT
    } srch_state_t;
endpackage
`default_nettype wire

// ----- hdl/hesrch_front.sv -----
// Front part: tracks the raster position and classifies each pixel as a store write.
`default_nettype none
module hesrch_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  wire logic [7:0] pixel,
    input  wire logic end_of_frame,
    input  wire logic [10:0] act_w,
    input  wire logic [10:0] act_h,
    output hesrch_pkg::load_cmd_t cmd
);
    import hesrch_pkg::*;
    logic [10:0] col_reg, col_next, row_reg, row_next;
    logic in_rows;

    always_comb
    begin
        in_rows = row_reg < act_h;
        col_next = col_reg;
        row_next = row_reg;
        if (in_rows)
        begin
            if (col_reg + 11'd1 >= act_w)
            begin
                col_next = '0;
                row_next = row_reg + 11'd1;
            end
            else
            begin
                col_next = col_reg + 11'd1;
            end
        end
        if (end_of_frame)
        begin
            col_next = '0;
            row_next = '0;
        end
        cmd.pixel = pixel;
        cmd.col = col_reg[XW-1:0];
        cmd.row = row_reg[YW-1:0];
        cmd.wr = in_rows && (col_reg < act_w);
        cmd.eof = end_of_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        take && end_of_frame |=> col_reg == '0 && row_reg == '0)
        else $error("position not cleared after end of frame");
    assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(col_reg) && $stable(row_reg))
        else $error("position moved without a transaction");
    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= 11'd512)
        else $error("row position out of range");
endmodule
`default_nettype wire

// ----- hdl/hesrch_queue.sv -----
// Short queue of classified load commands between front and back parts.
`default_nettype none
module hesrch_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  hesrch_pkg::load_cmd_t wr_data,
    output logic full,
    input  wire logic rd_en,
    output hesrch_pkg::load_cmd_t rd_data,
    output logic empty
);
    import hesrch_pkg::*;
    localparam int PW = $clog2(QDepth);
    load_cmd_t mem_reg [QDepth];
    logic [PW:0] wp_reg, rp_reg;

    assign empty = wp_reg == rp_reg;
    assign full = (wp_reg[PW] != rp_reg[PW]) && (wp_reg[PW-1:0] == rp_reg[PW-1:0]);
    assign rd_data = mem_reg[rp_reg[PW-1:0]];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg[PW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) <= (PW+1)'(QDepth))
        else $error("queue fill out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        full && !(rd_en && !empty) |=> full)
        else $error("full dropped without a read");
    assert property (@(posedge clk) disable iff (!rst_n)
        empty && !wr_en |=> empty)
        else $error("empty dropped without a write");
endmodule
`default_nettype wire

// ----- hdl/hesrch_back.sv -----
// Back part: frame memory, window search sequencer and result queue.
`default_nettype none
module hesrch_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  hesrch_pkg::load_cmd_t cmd,
    input  wire logic cmd_valid,
    output logic cmd_take,
    input  wire logic [10:0] act_w,
    input  wire logic [10:0] act_h,
    input  wire logic [7:0] thresh,
    output logic [8:0] point_x,
    output logic [8:0] point_y,
    output logic found,
    output logic last,
    output logic empty,
    input  wire logic pop
);
    import hesrch_pkg::*;
    localparam int CW = $clog2(ZoneSize * ZoneSize + 1);
    localparam int ZW = $clog2(ZoneSize);

    logic [7:0] mem [MaxWidth*MaxHeight];
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;
    srch_state_t st_reg, st_next;
    logic [10:0] col_reg, col_next, row_reg, row_next;
    logic [ZW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SumW-1:0] sum_reg, sum_next;
    logic [1:0] pts_reg, pts_next;
    logic jumped_reg, jumped_next, was_reg, was_next;
    logic [17:0] pt_reg [PointCount];
    logic [1:0] ek_reg, ek_next;
    logic hit_now, rd_valid_reg;
    logic [1:0] pend_reg;
    logic [10:0] rx, ry;

    always_comb
    begin
        rx = col_reg + 11'(dx_reg);
        ry = row_reg + 11'(dy_reg);
        raddr = {ry[YW-1:0], rx[XW-1:0]};
        hit_now = sum_reg > SumW'(thresh) * SumW'(ZoneSize * ZoneSize)
            + SumW'(ZoneSize * ZoneSize - 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.wr)
        begin
            mem[{cmd.row, cmd.col}] <= cmd.pixel;
        end
        rdata_reg <= mem[raddr];
    end

    assign cmd_take = cmd_valid && (st_reg == S_IDLE);

    always_comb
    begin
        st_next = st_reg;
        col_next = col_reg;
        row_next = row_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        pts_next = pts_reg;
        jumped_next = jumped_reg;
        was_next = was_reg;
        ek_next = ek_reg;
        if (rd_valid_reg)
        begin
            sum_next = sum_reg + SumW'(rdata_reg);
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (cmd_take && cmd.eof)
                begin
                    col_next = 11'(ZoneSize);
                    pts_next = '0;
                    jumped_next = 1'b0;
                    st_next = S_COL;
                end
            end
            S_COL:
            begin
                if (col_reg + 11'(ZoneSize) < act_w && pts_reg < 2'(PointCount))
                begin
                    was_next = jumped_reg;
                    row_next = 11'(3 * ZoneSize);
                    st_next = S_NEXT;
                    if (!(11'(3 * ZoneSize) + 11'(ZoneSize) < act_h))
                    begin
                        st_next = S_NEXT;
                        cnt_next = '0;
                    end
                    else
                    begin
                        dx_next = '0;
                        dy_next = '0;
                        cnt_next = '0;
                        sum_next = '0;
                        st_next = S_SUM;
                    end
                end
                else
                begin
                    ek_next = '0;
                    st_next = S_EMIT;
                end
            end
            S_SUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (dx_reg == ZW'(ZoneSize - 1))
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 1'b1;
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
                if (cnt_reg == CW'(ZoneSize * ZoneSize - 1))
                begin
                    st_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                st_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (hit_now)
                begin
                    pts_next = pts_reg + 1'b1;
                    cnt_next = '1;
                    st_next = S_NEXT;
                end
                else if (row_reg + 11'd1 + 11'(ZoneSize) < act_h)
                begin
                    row_next = row_reg + 11'd1;
                    dx_next = '0;
                    dy_next = '0;
                    cnt_next = '0;
                    sum_next = '0;
                    st_next = S_SUM;
                end
                else
                begin
                    cnt_next = '0;
                    st_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                st_next = S_COL;
                if (pts_reg == 2'd1)
                begin
                    col_next = col_reg + ((act_w - col_reg) >> 1);
                end
                else if (pts_reg == 2'd2)
                begin
                    if (was_reg || act_w < 11'(3 * ZoneSize))
                    begin
                        ek_next = '0;
                        st_next = S_EMIT;
                    end
                    else
                    begin
                        col_next = act_w - 11'(3 * ZoneSize);
                        jumped_next = 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 11'(ZoneSize);
                end
            end
            S_EMIT:
            begin
                if (!empty && pop)
                begin
                    ek_next = ek_reg + 1'b1;
                end
                if (pend_reg == 2'd0)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_EVAL && hit_now)
        begin
            pt_reg[pts_reg] <= {9'(row_reg + 11'(ZoneSize / 2)),
                                9'(col_reg + 11'(ZoneSize / 2))};
        end
    end

    // Result sequencing: pend counts results of the frame still to be popped.
    logic emitting;
    assign emitting = st_reg == S_EMIT;
    assign empty = !(emitting && pend_reg != 2'd0);
    always_comb
    begin
        if (pts_reg == 2'(PointCount))
        begin
            point_x = pt_reg[ek_reg][8:0];
            point_y = pt_reg[ek_reg][17:9];
            found = 1'b1;
            last = ek_reg == 2'(PointCount - 1);
        end
        else
        begin
            point_x = '0;
            point_y = '0;
            found = 1'b0;
            last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
            pts_reg <= '0;
            jumped_reg <= 1'b0;
            was_reg <= 1'b0;
            ek_reg <= '0;
            rd_valid_reg <= 1'b0;
            pend_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            col_reg <= col_next;
            row_reg <= row_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            pts_reg <= pts_next;
            jumped_reg <= jumped_next;
            was_reg <= was_next;
            ek_reg <= ek_next;
            rd_valid_reg <= st_reg == S_SUM;
            if (st_reg != S_EMIT && st_next == S_EMIT)
            begin
                pend_reg <= (pts_next == 2'(PointCount)) ? 2'(PointCount) : 2'd1;
            end
            else if (!empty && pop)
            begin
                pend_reg <= pend_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> st_reg == S_EMIT)
        else $error("result shown outside emit state");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> st_reg == S_IDLE)
        else $error("load command taken during search");
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && last |=> empty)
        else $error("result after last of frame");
endmodule
`default_nettype wire

// ----- hdl/horizon_edge_point_search.sv -----
// Top level of the horizon edge point search with its configuration registers.
//  channel   direction  handshake         payload
//  pixels    in         push / full       pixel, end_of_frame
//  results   out        pop / empty       point_x, point_y, found, last
//  config    in         APB psel/penable  image_width, image_height, bright_threshold
// Pixels load one per cycle, while the search is idle, through a four-entry queue into the frame memory.
// After end of frame the search reads the frame memory one pixel per cycle for each window
// tried, then compares the window sum with the threshold; no pixel is taken while it searches.
// Reset clears control state only; the frame memory holds nothing until loaded.
`default_nettype none
module horizon_edge_point_search (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire logic [7:0] pixel,
    input  wire logic end_of_frame,
    output logic empty,
    input  wire logic pop,
    output logic [8:0] point_x,
    output logic [8:0] point_y,
    output logic found,
    output logic last,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import hesrch_pkg::*;
    logic [9:0] width_reg, height_reg;
    logic [7:0] thresh_reg;
    logic [10:0] act_w, act_h;
    logic take, q_valid, q_empty, q_take;
    load_cmd_t f_cmd, q_cmd;

    assign pready = 1'b1;
    assign act_w = (width_reg > 10'(MaxWidth)) ? 11'(MaxWidth) : 11'(width_reg);
    assign act_h = (height_reg > 10'(MaxHeight)) ? 11'(MaxHeight) : 11'(height_reg);
    assign take = push && !full;
    assign q_valid = !q_empty;

    always_comb
    begin
        unique case (paddr[3:2])
            RegWidth: prdata = {22'd0, width_reg};
            RegHeight: prdata = {22'd0, height_reg};
            RegThresh: prdata = {24'd0, thresh_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 10'd512;
            height_reg <= 10'd512;
            thresh_reg <= 8'd128;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                RegWidth: width_reg <= pwdata[9:0];
                RegHeight: height_reg <= pwdata[9:0];
                RegThresh: thresh_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    hesrch_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .pixel(pixel),
        .end_of_frame(end_of_frame), .act_w(act_w), .act_h(act_h), .cmd(f_cmd)
    );

    hesrch_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(f_cmd), .full(full),
        .rd_en(q_take), .rd_data(q_cmd), .empty(q_empty)
    );

    hesrch_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_valid(q_valid), .cmd_take(q_take),
        .act_w(act_w), .act_h(act_h), .thresh(thresh_reg),
        .point_x(point_x), .point_y(point_y), .found(found), .last(last),
        .empty(empty), .pop(pop)
    );
endmodule
`default_nettype wire

// ----- bench/horizon_edge_point_search_tb.sv -----
// Randomized frame-level testbench for the horizon edge point search with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module horizon_edge_point_search_tb;
    import hesrch_pkg::*;

    typedef struct {
        logic [7:0] pixel;
        logic eof;
    } pixel_txn_t;

    typedef struct {
        logic [8:0] x;
        logic [8:0] y;
        logic found;
        logic last;
    } point_txn_t;

    localparam int KindHorizon = 0;
    localparam int KindNoise = 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [7:0] pixel = 8'd0;
    logic end_of_frame = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [8:0] point_x;
    logic [8:0] point_y;
    logic found;
    logic last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic pready;

    pixel_txn_t pixel_queue[$];
    point_txn_t point_queue[$];
    bit [7:0] frame_mem [0:MaxWidth*MaxHeight-1];
    int cfg_width = 512;
    int cfg_height = 512;
    int cfg_thresh = 128;
    int load_col = 0;
    int load_row = 0;
    int push_gap = 0;
    int pop_gap = 0;
    bit push_idle = 1'b1;
    bit pop_idle = 1'b1;
    int mismatches = 0;

    horizon_edge_point_search u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .pixel(pixel),
        .end_of_frame(end_of_frame), .empty(empty), .pop(pop), .point_x(point_x),
        .point_y(point_y), .found(found), .last(last), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int window_mean(int x0, int y0);
        int sum;
        sum = 0;
        for (int y = y0; y < y0 + ZoneSize; y++)
            for (int x = x0; x < x0 + ZoneSize; x++)
                sum += frame_mem[(y % MaxHeight) * MaxWidth + (x % MaxWidth)];
        return sum / (ZoneSize * ZoneSize);
    endfunction

    task automatic search_horizon();
        int w;
        int h;
        int col;
        int count;
        bit jumped;
        bit was_jump;
        bit stop;
        point_txn_t pts[PointCount];
        point_txn_t res;
        w = (cfg_width > MaxWidth) ? MaxWidth : cfg_width;
        h = (cfg_height > MaxHeight) ? MaxHeight : cfg_height;
        col = ZoneSize;
        count = 0;
        jumped = 1'b0;
        stop = 1'b0;
        while (!stop && col + ZoneSize < w && count < PointCount) begin
            was_jump = jumped;
            for (int row = 3 * ZoneSize; row + ZoneSize < h; row++) begin
                if (window_mean(col, row) > cfg_thresh) begin
                    pts[count].x = 9'(col + ZoneSize / 2);
                    pts[count].y = 9'(row + ZoneSize / 2);
                    count++;
                    break;
                end
            end
            if (count == 1) begin
                col += (w - col) / 2;
            end else if (count == 2) begin
                if (was_jump || w < 3 * ZoneSize) begin
                    stop = 1'b1;
                end else begin
                    col = w - 3 * ZoneSize;
                    jumped = 1'b1;
                end
            end else begin
                col += ZoneSize;
            end
        end
        if (count < PointCount) begin
            res.x = 9'd0;
            res.y = 9'd0;
            res.found = 1'b0;
            res.last = 1'b1;
            point_queue.push_back(res);
        end else begin
            for (int k = 0; k < PointCount; k++) begin
                pts[k].found = 1'b1;
                pts[k].last = (k == PointCount - 1);
                point_queue.push_back(pts[k]);
            end
        end
    endtask

    task automatic load_pixel(pixel_txn_t t);
        int w;
        int h;
        w = (cfg_width > MaxWidth) ? MaxWidth : cfg_width;
        h = (cfg_height > MaxHeight) ? MaxHeight : cfg_height;
        if (load_row < h) begin
            if (load_col < w)
                frame_mem[load_row * MaxWidth + load_col] = t.pixel;
            if (load_col + 1 >= w) begin
                load_col = 0;
                load_row++;
            end else begin
                load_col++;
            end
        end
        if (t.eof) begin
            load_col = 0;
            load_row = 0;
            search_horizon();
        end
    endtask

    always @(posedge clk)
    begin : pixel_driver
        bit taken;
        taken = push && !full;
        if (taken) begin
            load_pixel(pixel_queue[0]);
            void'(pixel_queue.pop_front());
            push_gap = push_idle ? $urandom_range(0, 6) : 0;
        end
        if (!push || taken) begin
            if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                push <= 1'b1;
                pixel <= pixel_queue[0].pixel;
                end_of_frame <= pixel_queue[0].eof;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : point_monitor
        point_txn_t want;
        if (pop && !empty) begin
            if (point_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: x=%0d y=%0d found=%0b last=%0b",
                             point_x, point_y, found, last);
            end else begin
                want = point_queue.pop_front();
                if (point_x !== want.x || point_y !== want.y || found !== want.found ||
                    last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d found=%0b last=%0b, got x=%0d y=%0d found=%0b last=%0b",
                                 want.x, want.y, want.found, want.last,
                                 point_x, point_y, found, last);
                end
            end
            pop_gap = pop_idle ? $urandom_range(0, 6) : 0;
        end
        if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic reg_write(logic [1:0] idx, int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegWidth: cfg_width = value & 10'h3FF;
            RegHeight: cfg_height = value & 10'h3FF;
            default: cfg_thresh = value & 8'hFF;
        endcase
    endtask

    task automatic send_frame(int w, int h, int thr, int kind, int extra, int cut, bit idle);
        int horizon;
        int n;
        pixel_txn_t t;
        while (pixel_queue.size() > 0 || push || point_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (w != cfg_width) reg_write(RegWidth, w);
        if (h != cfg_height) reg_write(RegHeight, h);
        if (thr != cfg_thresh) reg_write(RegThresh, thr);
        push_idle = idle && ($urandom_range(0, 3) != 0);
        pop_idle = idle && ($urandom_range(0, 3) != 0);
        if (w > MaxWidth) w = MaxWidth;
        if (h > MaxHeight) h = MaxHeight;
        horizon = $urandom_range(20, h);
        n = (cut > 0) ? cut : w * h + extra;
        for (int i = 0; i < n; i++) begin
            if (kind == KindNoise || i >= w * h)
                t.pixel = 8'($urandom_range(0, 255));
            else if ((i / w) >= horizon + ((i % w) / 8) % 3)
                t.pixel = 8'($urandom_range(140, 255));
            else
                t.pixel = 8'($urandom_range(0, 120));
            t.eof = (i == n - 1);
            pixel_queue.push_back(t);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_frame(48, 48, 100, KindHorizon, 0, 0, 1);
        send_frame(48, 48, 0, KindNoise, 0, 0, 1);
        send_frame(48, 48, 255, KindNoise, 0, 0, 1);
        send_frame(48, 48, 100, KindHorizon, 0, 1000, 1);
        send_frame(40, 41, 30, KindHorizon, 0, 0, 1);
        send_frame(40, 40, 30, KindHorizon, 0, 0, 1);
        send_frame(25, 48, 30, KindHorizon, 0, 0, 1);
        send_frame(64, 56, 128, KindHorizon, 37, 0, 1);
        send_frame(1023, 44, 90, KindHorizon, 0, 0, 0);
        send_frame(512, 42, 200, KindNoise, 0, 0, 0);
        send_frame(40, 512, 110, KindHorizon, 0, 0, 0);
        send_frame(40, 1023, 255, KindHorizon, 0, 0, 0);
        for (int f = 0; f < 16; f++)
            send_frame($urandom_range(40, 64), $urandom_range(40, 64),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(60, 200),
                       $urandom_range(0, 4) == 0 ? KindNoise : KindHorizon,
                       $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0, 0, 1);
        while (pixel_queue.size() > 0 || push || point_queue.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (point_queue.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("horizon_edge_point_search_tb: clean");
        else
            $display("horizon_edge_point_search_tb: errors");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("horizon_edge_point_search_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
